>>> sv/acred_pkg.sv
// shared types, codes and helpers for the access credential table
package acred_pkg;

  localparam int TABLE_DEPTH = 16;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_CARD   = 2'd2;
  localparam logic [1:0] ACT_KEYPAD = 2'd3;

  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_GRANTED = 2'd1;
  localparam logic [1:0] VERDICT_DENIED  = 2'd2;

  // "-1" packed with char 0 in the low byte
  localparam logic [63:0] TAG_MINUS_ONE = 64'h0000_0000_0000_312D;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] key_id;
    logic [63:0] code_chars;
    logic [63:0] tag_chars;
  } req_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       add_dropped;
    logic       entry_removed;
  } rsp_t;

  typedef struct packed {
    logic [15:0] ident;
    logic [63:0] code;
    logic [63:0] tag;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_next;
    logic ptr_inc;
    logic wr_add;
    logic wr_shift;
    logic cnt_dec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       scan_end;
    logic       last;
    logic       code_empty;
    logic       hit;
  } stat_t;

  // keep only the bytes before the first zero byte
  function automatic logic [63:0] str_trim(input logic [63:0] s);
    logic [63:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (s[8*i +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*i +: 8] = s[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

>>> sv/acred_dp.sv
// datapath: entry memory, request registers, fill count and scan pointer
module acred_dp #(
  parameter int TABLE_DEPTH = acred_pkg::TABLE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  acred_pkg::req_t  request,
  input  acred_pkg::cmd_t  cmd,
  output acred_pkg::stat_t stat
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  acred_pkg::entry_t mem [TABLE_DEPTH];
  acred_pkg::entry_t rdata;
  acred_pkg::entry_t wdata;

  logic [1:0]    action;
  logic [15:0]   key_id;
  logic [63:0]   code;
  logic [63:0]   tag;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] ptr_plus;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          wr_en;

  assign ptr_plus = ptr + CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= request.action;
      key_id <= request.key_id;
      code   <= acred_pkg::str_trim(request.code_chars);
      tag    <= acred_pkg::str_trim(request.tag_chars);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else begin
      if (cmd.wr_add) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.load) begin
        ptr <= '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr_plus;
      end
    end
  end

  // an add writes at the fill count, a shift moves entry ptr+1 down to ptr
  always_comb begin
    wr_en = cmd.wr_add | cmd.wr_shift;
    if (cmd.wr_add) begin
      waddr       = count[AW-1:0];
      wdata.ident = key_id;
      wdata.code  = code;
      wdata.tag   = (tag == 64'd0) ? acred_pkg::TAG_MINUS_ONE : tag;
    end else begin
      waddr = ptr[AW-1:0];
      wdata = rdata;
    end
    raddr = cmd.rd_next ? ptr_plus[AW-1:0] : ptr[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    stat.action     = action;
    stat.full       = (count == CW'(TABLE_DEPTH));
    stat.scan_end   = (ptr == count);
    stat.last       = (ptr_plus == count);
    stat.code_empty = (code == 64'd0);
    unique case (action)
      acred_pkg::ACT_DELETE: stat.hit = (rdata.ident == key_id);
      acred_pkg::ACT_CARD:   stat.hit = (rdata.tag == tag);
      acred_pkg::ACT_KEYPAD: stat.hit = (rdata.code == code);
      default:               stat.hit = 1'b0;
    endcase
  end

endmodule

>>> sv/acred_ctrl.sv
// controller: sequences add, scan and shift steps and registers the result
module acred_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  acred_pkg::stat_t stat,
  output acred_pkg::cmd_t  cmd,
  output logic             busy,
  output logic             done,
  output acred_pkg::rsp_t  result
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECIDE   = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CMP = 3'd3;
  localparam logic [2:0] S_SHIFT_RD = 3'd4;
  localparam logic [2:0] S_SHIFT_WR = 3'd5;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic            done_next;
  acred_pkg::rsp_t result_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    done_next   = 1'b0;
    result_next = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat.action)
          acred_pkg::ACT_ADD: begin
            done_next = 1'b1;
            state_next = S_IDLE;
            if (stat.full) begin
              result_next.add_dropped = 1'b1;
            end else begin
              cmd.wr_add = 1'b1;
            end
          end
          acred_pkg::ACT_KEYPAD: begin
            if (stat.code_empty) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          default: state_next = S_SCAN_RD;
        endcase
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          // ran off the end: delete finds nothing, attempts are denied
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (stat.action != acred_pkg::ACT_DELETE) begin
            result_next.verdict = acred_pkg::VERDICT_DENIED;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.hit) begin
          if (stat.action == acred_pkg::ACT_DELETE) begin
            state_next = S_SHIFT_RD;
          end else begin
            done_next           = 1'b1;
            result_next.verdict = acred_pkg::VERDICT_GRANTED;
            state_next          = S_IDLE;
          end
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat.last) begin
          cmd.cnt_dec               = 1'b1;
          done_next                 = 1'b1;
          result_next.entry_removed = 1'b1;
          state_next                = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_inc  = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

>>> sv/access_credential_table.sv
// top level of the access credential table
// A request (add, delete by id, card attempt, keypad attempt) is taken on a
// rising edge with start high and busy low; busy then stays high until the
// request is finished. Every request gives exactly one result, shown on
// result for one cycle with done high; the receiver cannot stall it.
// An add (stored or dropped) and a keypad attempt with an empty code finish
// straight after the decide step. A card or keypad attempt scans the stored
// entries in order until one matches or all have been read. A delete
// searches like an attempt, then moves each later entry down by one to close
// the gap and lowers the fill count.
// The entry memory has one read and one write port, and the scan reads one
// entry at a time, with a read step and then a compare step for each entry.
// The next request may be started in the cycle in which done is high.
// Reset empties the table (fill count to zero) and returns to idle; stored
// entries are not cleared since only entries below the count are read.
module access_credential_table #(
  parameter int TABLE_DEPTH = acred_pkg::TABLE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  acred_pkg::req_t request,
  output logic            busy,
  output logic            done,
  output acred_pkg::rsp_t result
);

  acred_pkg::cmd_t  cmd;
  acred_pkg::stat_t stat;

  acred_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  acred_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule
